[sv/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared constants and types for the masked gray patch extractor.
// ----------------------------------------------------------------------------
package gpe_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MASK_WIDTH  = 3'd0;
	localparam logic [2:0] REG_MASK_HEIGHT = 3'd1;
	localparam logic [2:0] REG_RAW_LEFT    = 3'd2;
	localparam logic [2:0] REG_RAW_TOP     = 3'd3;
	localparam logic [2:0] REG_RAW_RIGHT   = 3'd4;
	localparam logic [2:0] REG_RAW_BOTTOM  = 3'd5;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int SIDE_REG_W  = 7;
	localparam int BOX_W       = 17;
	localparam int MASK_ADDR_W = 12;

	// Item codes.
	localparam logic FUNC_MASK_WRITE = 1'b0;
	localparam logic FUNC_PIXEL      = 1'b1;

	// BT.601 luma weights in Q0.16.
	localparam logic [15:0] W_RED   = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	localparam int DEF_MASK_DEPTH    = 4096;
	localparam int DEF_MASK_SIDE_MAX = 64;
	localparam int DEF_COORD_BITS    = 12;

	// Side information that travels down the pipeline with each item.
	typedef struct packed {
		logic                   valid;
		logic                   func;
		logic                   last;
		logic [MASK_ADDR_W-1:0] waddr;
		logic                   wval;
	} side_t;

endpackage

[sv/gpe_luma.sv]
// ----------------------------------------------------------------------------
// gpe_luma
// Two-stage BT.601 luma: weighted products, then sum and clamp.
// ----------------------------------------------------------------------------
module gpe_luma (
	input  logic       clk,
	input  logic       adv,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] luma_s2
);

	logic [23:0] pr_s1, pg_s1, pb_s1;
	logic [25:0] sum;

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s1 <= red * gpe_pkg::W_RED;
			pg_s1 <= green * gpe_pkg::W_GREEN;
			pb_s1 <= blue * gpe_pkg::W_BLUE;
		end
	end

	assign sum = {2'b00, pr_s1} + {2'b00, pg_s1} + {2'b00, pb_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			luma_s2 <= (sum[25:24] != 2'b00) ? 8'hFF : sum[23:16];
		end
	end

endmodule

[sv/gpe_axis.sv]
// ----------------------------------------------------------------------------
// gpe_axis
// Box test and scaling of one pixel centre to a mask cell, with a pipelined
// restoring divider that settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module gpe_axis #(
	parameter int COORD_BITS    = gpe_pkg::DEF_COORD_BITS,
	parameter int MASK_SIDE_MAX = gpe_pkg::DEF_MASK_SIDE_MAX,
	localparam int SW = $clog2(MASK_SIDE_MAX + 1),
	localparam int QB = (MASK_SIDE_MAX > 1) ? $clog2(MASK_SIDE_MAX) : 1
) (
	input  logic                           clk,
	input  logic                           adv,
	input  logic [COORD_BITS-1:0]          coord,
	input  logic signed [gpe_pkg::BOX_W-1:0] lo,
	input  logic signed [gpe_pkg::BOX_W-1:0] hi,
	input  logic [SW-1:0]                  size,
	output logic                           in_box,
	output logic [QB-1:0]                  slot
);

	localparam int BW = gpe_pkg::BOX_W;
	localparam int DW = ((COORD_BITS + 4 > BW) ? COORD_BITS + 4 : BW) + 2;
	localparam int NW = BW + SW + 1;

	logic signed [DW-1:0] c, los, his, diff, span;

	logic          in_s1;
	logic [BW-1:0] dx_s1, span_s1;
	logic          in_s2;
	logic [NW-1:0] num_s2;
	logic [BW-1:0] span_s2;

	// Divider stages; entry j holds the state after j quotient bits.
	logic [NW-1:0] rem_d  [1:QB];
	logic [QB-1:0] quo_d  [1:QB];
	logic [BW-1:0] span_d [1:QB];
	logic          in_d   [1:QB];

	assign c    = $signed({{(DW-COORD_BITS-4){1'b0}}, coord, 4'h8});
	assign los  = DW'(lo);
	assign his  = DW'(hi);
	assign diff = c - los;
	assign span = his - los;

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1   <= (c >= los) && (c < his);
			dx_s1   <= diff[BW-1:0];
			span_s1 <= span[BW-1:0];
			in_s2   <= in_s1;
			num_s2  <= NW'(dx_s1 * size);
			span_s2 <= span_s1;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		logic [NW-1:0] rem_i, trial;
		logic [QB-1:0] quo_i;
		logic [BW-1:0] span_i;
		logic          in_i;
		if (j == 0) begin : g_first
			// The first stage takes the multiplier output.
			assign rem_i  = num_s2;
			assign quo_i  = '0;
			assign span_i = span_s2;
			assign in_i   = in_s2;
		end else begin : g_next
			assign rem_i  = rem_d[j];
			assign quo_i  = quo_d[j];
			assign span_i = span_d[j];
			assign in_i   = in_d[j];
		end
		assign trial = {{(NW-BW){1'b0}}, span_i} << K;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_i >= trial) begin
					rem_d[j+1]    <= rem_i - trial;
					quo_d[j+1]    <= quo_i | (QB'(1) << K);
				end else begin
					rem_d[j+1]    <= rem_i;
					quo_d[j+1]    <= quo_i;
				end
				span_d[j+1] <= span_i;
				in_d[j+1]   <= in_i;
			end
		end
	end

	assign in_box = in_d[QB];
	assign slot   = quo_d[QB];

endmodule

[sv/gpe_mask.sv]
// ----------------------------------------------------------------------------
// gpe_mask
// Mask cell index, mask store with one shared port, registered read.
// ----------------------------------------------------------------------------
module gpe_mask #(
	parameter int MASK_DEPTH    = gpe_pkg::DEF_MASK_DEPTH,
	parameter int MASK_SIDE_MAX = gpe_pkg::DEF_MASK_SIDE_MAX,
	localparam int SW = $clog2(MASK_SIDE_MAX + 1),
	localparam int QB = (MASK_SIDE_MAX > 1) ? $clog2(MASK_SIDE_MAX) : 1
) (
	input  logic          clk,
	input  logic          adv,
	input  gpe_pkg::side_t side_in,
	input  logic          in_box,
	input  logic [QB-1:0] row,
	input  logic [QB-1:0] col,
	input  logic [SW-1:0] mw,
	output logic          hit
);

	localparam int AW = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
	localparam int IW = QB + SW + 1;
	localparam int CW = (IW > 17) ? IW : 17;

	logic mem [MASK_DEPTH];

	logic [IW-1:0]  idx_s1;
	logic           ok_s1;
	gpe_pkg::side_t side_s1;
	logic           rd_q;
	logic           ok_s2;
	logic [CW-1:0]  widx;

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= IW'(row * mw) + IW'(col);
			ok_s1   <= in_box;
			side_s1 <= side_in;
		end
	end

	assign widx = CW'(side_s1.waddr);

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2 <= ok_s1 && (CW'(idx_s1) < CW'(MASK_DEPTH));
			if (side_s1.valid && side_s1.func == gpe_pkg::FUNC_MASK_WRITE) begin
				if (widx < CW'(MASK_DEPTH)) begin
					mem[widx[AW-1:0]] <= side_s1.wval;
				end
			end else begin
				rd_q <= mem[idx_s1[AW-1:0]];
			end
		end
	end

	assign hit = ok_s2 && rd_q;

endmodule

[sv/masked_gray_patch_extract.sv]
// ----------------------------------------------------------------------------
// masked_gray_patch_extract
// Streaming RGB to BT.601 luma with a box-scaled one-bit mask.
// ----------------------------------------------------------------------------
// Usage: items enter on the input channel (in_valid / in_stall). An item with
// func at zero writes one mask cell and gives no result; an item with func at
// one is a pixel and gives exactly one result item on the output channel
// (out_valid / out_stall): gray, kept and last_out.
// Configuration registers are written on cfg_we / cfg_index / cfg_data while
// no item is in flight; they reset to zero, which leaves masking off.
// Throughput is one item per cycle while the output is not stalled. The
// pipeline has Q + 4 register stages, where Q is the quotient width of the
// cell divider (log2 of MASK_SIDE_MAX, six at the default): box test,
// multiply, Q divider stages, cell index, mask read.
// The whole pipeline moves together: in_stall is high exactly when a result
// waits at the output and the receiver stalls, so nothing is lost or
// repeated. Reset clears the valid bits and the configuration; the mask
// store keeps no reset and must be written before it is read.
// ----------------------------------------------------------------------------
module masked_gray_patch_extract #(
	parameter int MASK_DEPTH    = gpe_pkg::DEF_MASK_DEPTH,
	parameter int MASK_SIDE_MAX = gpe_pkg::DEF_MASK_SIDE_MAX,
	parameter int COORD_BITS    = gpe_pkg::DEF_COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gpe_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [gpe_pkg::MASK_ADDR_W-1:0]   mask_addr,
	input  logic                              mask_value,
	input  logic [7:0]                        red,
	input  logic [7:0]                        green,
	input  logic [7:0]                        blue,
	input  logic [COORD_BITS-1:0]             src_x,
	input  logic [COORD_BITS-1:0]             src_y,
	input  logic                              last_pixel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        gray,
	output logic                              kept,
	output logic                              last_out
);

	localparam int SW   = $clog2(MASK_SIDE_MAX + 1);
	localparam int QB   = (MASK_SIDE_MAX > 1) ? $clog2(MASK_SIDE_MAX) : 1;
	localparam int LAX  = QB + 2;
	localparam int LTOT = LAX + 2;
	localparam int BW   = gpe_pkg::BOX_W;

	// Configuration registers.
	logic [gpe_pkg::SIDE_REG_W-1:0] mask_width_q, mask_height_q;
	logic signed [BW-1:0] raw_left_q, raw_top_q, raw_right_q, raw_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q  <= '0;
			mask_height_q <= '0;
			raw_left_q    <= '0;
			raw_top_q     <= '0;
			raw_right_q   <= '0;
			raw_bottom_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gpe_pkg::REG_MASK_WIDTH:  mask_width_q  <= cfg_data[6:0];
				gpe_pkg::REG_MASK_HEIGHT: mask_height_q <= cfg_data[6:0];
				gpe_pkg::REG_RAW_LEFT:    raw_left_q    <= cfg_data;
				gpe_pkg::REG_RAW_TOP:     raw_top_q     <= cfg_data;
				gpe_pkg::REG_RAW_RIGHT:   raw_right_q   <= cfg_data;
				gpe_pkg::REG_RAW_BOTTOM:  raw_bottom_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Mask sizes saturated to the largest side the store supports.
	logic [SW-1:0] mw, mh;
	logic          mask_on;

	assign mw = ({2'b00, mask_width_q} > 9'(MASK_SIDE_MAX)) ?
		SW'(MASK_SIDE_MAX) : SW'(mask_width_q);
	assign mh = ({2'b00, mask_height_q} > 9'(MASK_SIDE_MAX)) ?
		SW'(MASK_SIDE_MAX) : SW'(mask_height_q);
	assign mask_on = (mask_width_q != '0) && (mask_height_q != '0);

	// The pipeline advances unless a result sits at the output and is stalled.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Side information and luma travel in step with the axis units.
	gpe_pkg::side_t side_d [1:LTOT];
	logic [7:0]     luma_s2;
	logic [7:0]     luma_d [3:LTOT];

	// Only the valid bits take the reset; the rest just follows along.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LTOT; i++) side_d[i].valid <= 1'b0;
		end else if (adv) begin
			side_d[1].valid <= in_valid;
			side_d[1].func  <= func;
			side_d[1].last  <= last_pixel;
			side_d[1].waddr <= mask_addr;
			side_d[1].wval  <= mask_value;
			for (int i = 2; i <= LTOT; i++) side_d[i] <= side_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			luma_d[3] <= luma_s2;
			for (int i = 4; i <= LTOT; i++) luma_d[i] <= luma_d[i-1];
		end
	end

	gpe_luma u_luma (
		.clk     (clk),
		.adv     (adv),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.luma_s2 (luma_s2)
	);

	logic          in_x, in_y;
	logic [QB-1:0] col, row;

	gpe_axis #(.COORD_BITS(COORD_BITS), .MASK_SIDE_MAX(MASK_SIDE_MAX)) u_axis_x (
		.clk    (clk),
		.adv    (adv),
		.coord  (src_x),
		.lo     (raw_left_q),
		.hi     (raw_right_q),
		.size   (mw),
		.in_box (in_x),
		.slot   (col)
	);

	gpe_axis #(.COORD_BITS(COORD_BITS), .MASK_SIDE_MAX(MASK_SIDE_MAX)) u_axis_y (
		.clk    (clk),
		.adv    (adv),
		.coord  (src_y),
		.lo     (raw_top_q),
		.hi     (raw_bottom_q),
		.size   (mh),
		.in_box (in_y),
		.slot   (row)
	);

	// Mask writes are applied at the same stage where pixels read the store,
	// so every pixel sees exactly the writes that came before it.
	logic hit;

	gpe_mask #(.MASK_DEPTH(MASK_DEPTH), .MASK_SIDE_MAX(MASK_SIDE_MAX)) u_mask (
		.clk     (clk),
		.adv     (adv),
		.side_in (side_d[LAX]),
		.in_box  (in_x && in_y),
		.row     (row),
		.col     (col),
		.mw      (mw),
		.hit     (hit)
	);

	assign out_valid = side_d[LTOT].valid && (side_d[LTOT].func == gpe_pkg::FUNC_PIXEL);
	assign kept      = !mask_on || hit;
	assign gray      = kept ? luma_d[LTOT] : 8'h00;
	assign last_out  = side_d[LTOT].last;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kept |-> gray == 8'h00)
		else $error("dropped pixel has nonzero gray");

	a_mask_off_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mask_on |-> kept)
		else $error("pixel dropped while masking is off");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gray) && $stable(last_out))
		else $error("stalled result changed");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

endmodule
